>>> src/bsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and constants shared by the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int BLOCK_BYTES = 262144;
  localparam int MAX_SLOTS   = 32768;
  localparam int MAP_DEPTH   = (MAX_SLOTS + 7) / 8;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);

  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_MARK  = 3'd1;
  localparam logic [2:0] CMD_FIND  = 3'd2;
  localparam logic [2:0] CMD_TEST  = 3'd3;
  localparam logic [2:0] CMD_CLRM  = 3'd4;
  localparam logic [2:0] CMD_SWEEP = 3'd5;

  localparam logic [9:0] SLOT_BYTES_RST = 10'd8;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [17:0] byte_offset;
  } bsa_in_t;

  typedef struct packed {
    logic        ok;
    logic [14:0] slot_index;
    logic [17:0] base_offset;
    logic        newly_marked;
    logic        slot_marked;
    logic [15:0] live_slots;
    logic [15:0] freed_slots;
    logic        block_empty;
  } bsa_out_t;

endpackage
`default_nettype wire

>>> src/bitmap_slot_allocator_mark_sweep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_mark_sweep
// Slot allocator for one heap block with allocation and mark bitmaps.
// ----------------------------------------------------------------------------
// Both bitmaps live in one 4096-word memory, one byte of each per word, and
// every command walks it through a single read port and a single write port.
// After reset and after each slot_bytes write the block runs a clearing pass
// over all 4096 words, then a division and a step that sets the slot count,
// taking no beat meanwhile. Mark, find base and test mark go through a
// one-bit-per-cycle divider and end early when the slot lies past the end.
// Allocate reads and checks one bitmap byte after another from the cursor;
// clear marks and sweep read and write back every bitmap byte in use. A
// stalled result holds the block in its done state. A new beat is taken
// while the previous result still waits.
module bitmap_slot_allocator_mark_sweep (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [9:0]          cfg_wdata,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  bsa_pkg::bsa_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output bsa_pkg::bsa_out_t   out_data
);
  import bsa_pkg::*;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_TDIV    = 4'd1;
  localparam logic [3:0] S_TSET    = 4'd2;
  localparam logic [3:0] S_IDLE    = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_LOOK    = 4'd5;
  localparam logic [3:0] S_MRD     = 4'd6;
  localparam logic [3:0] S_MCK     = 4'd7;
  localparam logic [3:0] S_SCAN_RD = 4'd8;
  localparam logic [3:0] S_SCAN_CK = 4'd9;
  localparam logic [3:0] S_WALK_RD = 4'd10;
  localparam logic [3:0] S_WALK_WR = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) c = c + {3'd0, v[i]};
    return c;
  endfunction

  logic [15:0] mem [MAP_DEPTH];
  logic [15:0] rd_q_r;

  logic [3:0]  state_r, state_nxt;
  logic [9:0]  slot_bytes_r, slot_bytes_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic        ok_r, ok_nxt, newly_r, newly_nxt, marked_r, marked_nxt, empty_r, empty_nxt;
  logic [14:0] slot_r, slot_nxt;
  logic [15:0] freed_r, freed_nxt, live_r, live_nxt, acc_r, acc_nxt;
  logic [14:0] cursor_r, cursor_nxt;
  logic [15:0] slot_total_r, slot_total_nxt;
  logic [12:0] map_bytes_r, map_bytes_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [MAP_AW-1:0] addr_r, addr_nxt;
  logic [12:0] steps_r, steps_nxt;
  logic        out_valid_r, out_valid_nxt;
  bsa_out_t    out_r, out_nxt;

  logic        wr_en;
  logic [15:0] wr_data;

  logic [6:0]  div_d;
  logic [7:0]  div_t;
  logic        div_ge;
  logic [6:0]  div_rem;
  logic [9:0]  eff_size;
  logic [7:0]  scan_v;
  logic [2:0]  scan_bit;
  logic [14:0] scan_slot;
  logic [7:0]  walk_a, walk_m, walk_live, walk_dead;
  logic [15:0] tot_cap;
  logic [24:0] prod;
  logic [MAP_AW-1:0] addr_inc;
  logic [11:0] cur_byte;

  assign div_d    = (slot_bytes_r[9:3] == 7'd0) ? 7'd1 : slot_bytes_r[9:3];
  assign eff_size = {div_d, 3'b000};
  assign div_t    = {rem_r, dvd_r[15]};
  assign div_ge   = div_t >= {1'b0, div_d};
  assign div_rem  = div_ge ? 7'(div_t - {1'b0, div_d}) : div_t[6:0];
  assign addr_inc = addr_r + 1'b1;
  assign cur_byte = cursor_r[14:3];

  always_comb begin
    scan_v   = rd_q_r[7:0];
    scan_bit = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (!scan_v[i]) scan_bit = 3'(i);
    end
  end
  assign scan_slot = {addr_r, scan_bit};

  assign walk_a    = rd_q_r[7:0];
  assign walk_m    = rd_q_r[15:8];
  assign walk_live = walk_a & walk_m;
  assign walk_dead = walk_a & ~walk_m;
  assign tot_cap   = (dvd_r > 16'(MAX_SLOTS)) ? 16'(MAX_SLOTS) : dvd_r;
  assign prod      = 25'(slot_r) * 25'(eff_size);

  always_comb begin
    state_nxt      = state_r;
    slot_bytes_nxt = slot_bytes_r;
    cmd_nxt        = cmd_r;
    ok_nxt         = ok_r;
    newly_nxt      = newly_r;
    marked_nxt     = marked_r;
    empty_nxt      = empty_r;
    slot_nxt       = slot_r;
    freed_nxt      = freed_r;
    live_nxt       = live_r;
    acc_nxt        = acc_r;
    cursor_nxt     = cursor_r;
    slot_total_nxt = slot_total_r;
    map_bytes_nxt  = map_bytes_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    steps_nxt      = steps_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_data        = rd_q_r;

    unique case (state_r)
      S_CLR: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        addr_nxt = addr_inc;
        if (addr_r == '1) begin
          dvd_nxt   = 16'(BLOCK_BYTES / 8);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV, S_DIV: begin
        dvd_nxt = {dvd_r[14:0], div_ge};
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) state_nxt = (state_r == S_TDIV) ? S_TSET : S_LOOK;
      end
      S_TSET: begin
        slot_total_nxt = tot_cap;
        map_bytes_nxt  = 13'((17'(tot_cap) + 17'd7) >> 3);
        state_nxt      = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.cmd;
          ok_nxt     = 1'b0;
          newly_nxt  = 1'b0;
          marked_nxt = 1'b0;
          empty_nxt  = 1'b0;
          slot_nxt   = '0;
          freed_nxt  = '0;
          acc_nxt    = '0;
          steps_nxt  = map_bytes_r;
          unique case (in_data.cmd)
            CMD_ALLOC: begin
              addr_nxt  = ({1'b0, cur_byte} >= map_bytes_r) ? '0 : cur_byte;
              state_nxt = S_SCAN_RD;
            end
            CMD_MARK, CMD_FIND, CMD_TEST: begin
              dvd_nxt   = {1'b0, in_data.byte_offset[17:3]};
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
            CMD_CLRM, CMD_SWEEP: begin
              addr_nxt  = '0;
              state_nxt = S_WALK_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        if (dvd_r >= slot_total_r) begin
          state_nxt = S_DONE;
        end else begin
          addr_nxt  = dvd_r[14:3];
          state_nxt = S_MRD;
        end
      end
      S_MRD: state_nxt = S_MCK;
      S_MCK: begin
        if (rd_q_r[dvd_r[2:0]]) begin
          ok_nxt     = 1'b1;
          slot_nxt   = dvd_r[14:0];
          marked_nxt = rd_q_r[{1'b1, dvd_r[2:0]}];
          if (cmd_r == CMD_MARK && !rd_q_r[{1'b1, dvd_r[2:0]}]) begin
            wr_en      = 1'b1;
            wr_data    = rd_q_r | (16'd1 << {1'b1, dvd_r[2:0]});
            newly_nxt  = 1'b1;
            marked_nxt = 1'b1;
          end
        end
        state_nxt = S_DONE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CK;
      S_SCAN_CK: begin
        if (scan_v != 8'hFF && {1'b0, scan_slot} < slot_total_r) begin
          wr_en      = 1'b1;
          wr_data    = rd_q_r | (16'd1 << {1'b0, scan_bit});
          cursor_nxt = scan_slot + 1'b1;
          live_nxt   = live_r + 1'b1;
          ok_nxt     = 1'b1;
          slot_nxt   = scan_slot;
          marked_nxt = rd_q_r[{1'b1, scan_bit}];
          state_nxt  = S_DONE;
        end else if (steps_r <= 13'd1) begin
          state_nxt = S_DONE;
        end else begin
          steps_nxt = steps_r - 1'b1;
          addr_nxt  = ({1'b0, addr_inc} == map_bytes_r) ? '0 : addr_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_WALK_RD: state_nxt = S_WALK_WR;
      S_WALK_WR: begin
        wr_en = 1'b1;
        if (cmd_r == CMD_SWEEP) begin
          wr_data   = {walk_m, walk_live};
          freed_nxt = freed_r + {12'd0, pop8(walk_dead)};
          acc_nxt   = acc_r + {12'd0, pop8(walk_live)};
        end else begin
          wr_data = {8'd0, walk_a};
        end
        if (steps_r <= 13'd1) begin
          if (cmd_r == CMD_SWEEP) begin
            live_nxt   = acc_nxt;
            cursor_nxt = '0;
            empty_nxt  = (acc_nxt == 16'd0);
          end
          state_nxt = S_DONE;
        end else begin
          steps_nxt = steps_r - 1'b1;
          addr_nxt  = addr_inc;
          state_nxt = S_WALK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.ok           = ok_r;
          out_nxt.slot_index   = slot_r;
          out_nxt.base_offset  = ok_r ? prod[17:0] : 18'd0;
          out_nxt.newly_marked = newly_r;
          out_nxt.slot_marked  = marked_r;
          out_nxt.live_slots   = live_r;
          out_nxt.freed_slots  = freed_r;
          out_nxt.block_empty  = empty_r;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A register write empties the block and restarts the clearing pass.
    if (cfg_we) begin
      slot_bytes_nxt = cfg_wdata;
      cursor_nxt     = '0;
      live_nxt       = '0;
      addr_nxt       = '0;
      state_nxt      = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      slot_bytes_r <= SLOT_BYTES_RST;
      cursor_r     <= '0;
      live_r       <= '0;
      addr_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_bytes_r <= slot_bytes_nxt;
      cursor_r     <= cursor_nxt;
      live_r       <= live_nxt;
      addr_r       <= addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ok_r         <= ok_nxt;
    newly_r      <= newly_nxt;
    marked_r     <= marked_nxt;
    empty_r      <= empty_nxt;
    slot_r       <= slot_nxt;
    freed_r      <= freed_nxt;
    acc_r        <= acc_nxt;
    slot_total_r <= slot_total_nxt;
    map_bytes_r  <= map_bytes_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    steps_r      <= steps_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_r] <= wr_data;
    rd_q_r <= mem[addr_r];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
